// ===== src/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg
// Shared constants and types for the preamble-gated symbol slicer.
// ----------------------------------------------------------------------------
package pss_pkg;

  // Datapath sizes
  localparam int WINDOW_LEN   = 16;
  localparam int SAMPLE_WIDTH = 16;
  localparam int FILL_W       = $clog2(WINDOW_LEN + 1);

  // Configuration register widths
  localparam int PATTERN_W = 16;
  localparam int COUNT_W   = 13;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_PATTERN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_SYMBOLS  = 1'b1;

  // Reset values
  localparam logic [PATTERN_W-1:0] PATTERN_RESET = 16'hFE19;
  localparam logic [COUNT_W-1:0]   PAYLOAD_RESET = 13'd64;

  // One result beat from the slicer core
  typedef struct packed {
    logic       valid;
    logic [1:0] symbol;
    logic       last_of_burst;
  } pss_result_t;

endpackage

// ===== src/preamble_gated_symbol_slicer.sv =====
// ----------------------------------------------------------------------------
// preamble_gated_symbol_slicer
// Path: a result beat reaches symbol_valid from the sample beat that closes
// it through the input register, then the result register.
// Throughput: one sample beat per cycle; the input register holds a sample
// while the result register waits on symbol_stall.
// Reset: synchronous; block starts muted with the default pattern and length.
// ----------------------------------------------------------------------------
module preamble_gated_symbol_slicer (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration writes
  input  logic                                  cfg_we,
  input  logic [pss_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0]        cfg_data,
  // sample channel
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [pss_pkg::SAMPLE_WIDTH-1:0] sample,
  // symbol channel
  output logic                                  symbol_valid,
  input  logic                                  symbol_stall,
  output logic [1:0]                            symbol,
  output logic                                  last_of_burst
);
  import pss_pkg::*;

  logic [PATTERN_W-1:0] preamble_pattern;
  logic [COUNT_W-1:0]   payload_symbols;

  logic                 pipe_valid;
  logic                 pipe_neg;
  logic                 pipe_pos;
  logic                 pipe_go;
  logic                 in_take;
  pss_result_t          result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_pattern <= PATTERN_RESET;
      payload_symbols  <= PAYLOAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PREAMBLE_PATTERN: preamble_pattern <= cfg_data[PATTERN_W-1:0];
        REG_PAYLOAD_SYMBOLS:  payload_symbols  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control: the held sample moves on when the result slot is free
  assign pipe_go      = pipe_valid && (!symbol_valid || !symbol_stall);
  assign sample_stall = pipe_valid && !pipe_go;
  assign in_take      = sample_valid && !sample_stall;

  // Input register: keep only the sign and zero decisions
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (in_take || pipe_go) begin
      pipe_valid <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pipe_neg <= sample[SAMPLE_WIDTH-1];
      pipe_pos <= !sample[SAMPLE_WIDTH-1] && (sample != '0);
    end
  end

  pss_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (pipe_go),
    .sample_neg (pipe_neg),
    .sample_pos (pipe_pos),
    .pattern    (preamble_pattern),
    .payload    (payload_symbols),
    .result     (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_valid <= 1'b0;
    end else if (!symbol_valid || !symbol_stall) begin
      symbol_valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid && (!symbol_valid || !symbol_stall)) begin
      symbol        <= result.symbol;
      last_of_burst <= result.last_of_burst;
    end
  end

endmodule

// ===== src/pss_core.sv =====
// ----------------------------------------------------------------------------
// pss_core
// Preamble search and symbol pairing state; one sample per step, result
// decided in the same cycle.
// ----------------------------------------------------------------------------
module pss_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          sample_neg,
  input  logic                          sample_pos,
  input  logic [pss_pkg::PATTERN_W-1:0] pattern,
  input  logic [pss_pkg::COUNT_W-1:0]   payload,
  output pss_pkg::pss_result_t          result
);
  import pss_pkg::*;

  logic [WINDOW_LEN-1:0] sign_window, sign_window_next;
  logic [FILL_W-1:0]     fill_count, fill_count_next;
  logic                  unmuted, unmuted_next;
  logic [COUNT_W-1:0]    symbol_count, symbol_count_next;
  logic                  second_half, second_half_next;
  logic                  held_bit, held_bit_next;

  logic [COUNT_W-1:0]    count_inc;
  logic [COUNT_W-1:0]    limit;
  logic                  last;

  assign count_inc = symbol_count + COUNT_W'(1);
  // zero burst length acts as one
  assign limit = (payload == '0) ? COUNT_W'(1) : payload;
  assign last  = (count_inc >= limit);

  // Next-state and result decode
  always_comb begin
    sign_window_next  = sign_window;
    fill_count_next   = fill_count;
    unmuted_next      = unmuted;
    symbol_count_next = symbol_count;
    second_half_next  = second_half;
    held_bit_next     = held_bit;
    result            = '0;

    if (step) begin
      if (!unmuted) begin
        // muted: shift sign in, look for the preamble
        sign_window_next = {sign_window[WINDOW_LEN-2:0], ~sample_neg};
        if (fill_count < FILL_W'(WINDOW_LEN))
          fill_count_next = fill_count + FILL_W'(1);
        if ((fill_count_next >= FILL_W'(WINDOW_LEN)) &&
            (sign_window_next == WINDOW_LEN'(pattern))) begin
          unmuted_next      = 1'b1;
          symbol_count_next = '0;
          second_half_next  = 1'b0;
          held_bit_next     = 1'b0;
        end
      end else if (!second_half) begin
        // first sample of a symbol
        held_bit_next    = sample_pos;
        second_half_next = 1'b1;
      end else begin
        // second sample closes the symbol
        result.valid         = 1'b1;
        result.symbol        = {held_bit, sample_pos};
        result.last_of_burst = last;
        second_half_next     = 1'b0;
        held_bit_next        = 1'b0;
        if (last) begin
          unmuted_next      = 1'b0;
          symbol_count_next = '0;
        end else begin
          symbol_count_next = count_inc;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sign_window  <= '0;
      fill_count   <= '0;
      unmuted      <= 1'b0;
      symbol_count <= '0;
      second_half  <= 1'b0;
      held_bit     <= 1'b0;
    end else begin
      sign_window  <= sign_window_next;
      fill_count   <= fill_count_next;
      unmuted      <= unmuted_next;
      symbol_count <= symbol_count_next;
      second_half  <= second_half_next;
      held_bit     <= held_bit_next;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the preamble-gated symbol slicer. A scoreboard tracks the sign
// window, mute state and symbol pairing, predicts each symbol beat, and
// compares it field by field against the DUT. Directed beats come first,
// then random preamble bursts and noise under varying backpressure.
// ----------------------------------------------------------------------------
module testbench;
  import pss_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 4000;
  localparam int SETTLE_TICKS = 4;

  typedef struct packed {
    logic [1:0] symbol;
    logic       last;
  } slice_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_PREAMBLE_PATTERN;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     sample_valid = 1'b0;
  logic                     sample_stall;
  logic signed [SAMPLE_WIDTH-1:0] sample = '0;
  logic                     symbol_valid;
  logic                     symbol_stall = 1'b0;
  logic [1:0]               symbol;
  logic                     last_of_burst;

  // Stimulus and scoreboard storage
  logic [SAMPLE_WIDTH-1:0]  pending_samples[$];
  slice_t                   expected_symbols[$];
  int                       mismatch_count = 0;
  int                       send_gap_pct = 0;
  int                       recv_stall_pct = 0;
  int                       hold_requests = 0;
  int                       holds_done = 0;
  int                       hold_left = 0;
  int                       stuck_cycles = 0;

  // Scoreboard copy of the slicer state and its registers
  logic [PATTERN_W-1:0]     pattern_reg = PATTERN_RESET;
  logic [COUNT_W-1:0]       burst_len_reg = PAYLOAD_RESET;
  logic [WINDOW_LEN-1:0]    win_bits = '0;
  int                       win_fill = 0;
  logic                     in_burst = 1'b0;
  logic [COUNT_W-1:0]       symbols_sent = '0;
  logic                     pair_open = 1'b0;
  logic                     first_pos = 1'b0;

  preamble_gated_symbol_slicer uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .sample        (sample),
    .symbol_valid  (symbol_valid),
    .symbol_stall  (symbol_stall),
    .symbol        (symbol),
    .last_of_burst (last_of_burst)
  );

  // Clock and reset
  initial begin
    fork
      forever #4 clk = ~clk;
      begin
        repeat (11) @(posedge clk);
        rst <= 1'b0;
      end
    join
  end

  // Predict the result of one accepted sample beat
  task automatic slice_sample(input logic [SAMPLE_WIDTH-1:0] s);
    logic               neg;
    logic               pos;
    logic [COUNT_W-1:0] limit;
    slice_t             res;
    neg = s[SAMPLE_WIDTH-1];
    pos = !neg && (s != '0);
    if (!in_burst) begin
      win_bits = {win_bits[WINDOW_LEN-2:0], !neg};
      if (win_fill < WINDOW_LEN) win_fill++;
      if (win_fill >= WINDOW_LEN && win_bits == pattern_reg[WINDOW_LEN-1:0]) begin
        in_burst = 1'b1;
        symbols_sent = '0;
        pair_open = 1'b0;
        first_pos = 1'b0;
      end
    end else if (!pair_open) begin
      first_pos = pos;
      pair_open = 1'b1;
    end else begin
      res.symbol = {first_pos, pos};
      pair_open = 1'b0;
      first_pos = 1'b0;
      symbols_sent = symbols_sent + COUNT_W'(1);
      // a zero length acts as one
      limit = (burst_len_reg == '0) ? COUNT_W'(1) : burst_len_reg;
      res.last = (symbols_sent >= limit);
      if (res.last) begin
        in_burst = 1'b0;
        symbols_sent = '0;
      end
      expected_symbols.insert(expected_symbols.size(), res);
    end
  endtask

  // Sample driver: holds a stalled beat, otherwise offers the next one
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      sample <= '0;
    end else begin
      if (sample_valid && !sample_stall) begin
        slice_sample(sample);
        pending_samples.delete(0);
      end
      if (!sample_valid || !sample_stall) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          sample_valid <= 1'b1;
          sample <= pending_samples[0];
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Symbol monitor and receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      symbol_stall <= 1'b0;
    end else begin
      if (symbol_valid && !symbol_stall) begin
        if (expected_symbols.size() == 0) begin
          $display("%0t: unexpected symbol beat: expected none, got symbol %0d last %0b",
                   $time, symbol, last_of_burst);
          mismatch_count++;
        end else begin
          if (symbol !== expected_symbols[0].symbol) begin
            $display("%0t: symbol mismatch: expected %0d, got %0d",
                     $time, expected_symbols[0].symbol, symbol);
            mismatch_count++;
          end
          if (last_of_burst !== expected_symbols[0].last) begin
            $display("%0t: last_of_burst mismatch: expected %0b, got %0b",
                     $time, expected_symbols[0].last, last_of_burst);
            mismatch_count++;
          end
          expected_symbols.delete(0);
        end
      end
      // long hold-off so the pipeline backs up into the sample channel
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left = HOLD_CYCLES;
        symbol_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        symbol_stall <= 1'b1;
      end else begin
        symbol_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: no beat on either channel for too long
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (symbol_valid && !symbol_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STUCK_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic logic [SAMPLE_WIDTH-1:0] any_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      2: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      3: return '1;
      4: return SAMPLE_WIDTH'(1);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  // Sample with a chosen sign; zero counts as non-negative
  function automatic logic [SAMPLE_WIDTH-1:0] signed_sample(input logic nonneg);
    logic [SAMPLE_WIDTH-1:0] r;
    r = SAMPLE_WIDTH'($urandom);
    case ($urandom_range(3))
      0: return nonneg ? '0 : {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      1: return nonneg ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} : '1;
      default: return {!nonneg, r[SAMPLE_WIDTH-2:0]};
    endcase
  endfunction

  task automatic push_preamble(input logic [PATTERN_W-1:0] pat);
    for (int i = WINDOW_LEN - 1; i >= 0; i--)
      pending_samples.insert(pending_samples.size(), signed_sample(pat[i]));
  endtask

  task automatic push_noise(input int count);
    for (int i = 0; i < count; i++)
      pending_samples.insert(pending_samples.size(), any_sample());
  endtask

  // Mostly well-formed bursts, some cut short, some bare noise
  task automatic push_traffic(input int budget);
    int added;
    int len;
    added = 0;
    while (added < budget) begin
      if ($urandom_range(9) < 7) begin
        push_preamble(pattern_reg);
        len = 2 * burst_len_reg;
        if ($urandom_range(9) == 0) len = $urandom_range(len);
        push_noise(len);
        added += WINDOW_LEN + len;
      end else begin
        len = $urandom_range(1, 12);
        push_noise(len);
        added += len;
      end
    end
  endtask

  // Wait for all beats to drain, then let in-flight samples settle
  task automatic settle();
    while (pending_samples.size() != 0 || expected_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PREAMBLE_PATTERN) pattern_reg = data[PATTERN_W-1:0];
    else burst_len_reg = data[COUNT_W-1:0];
  endtask

  task automatic push_pair(input logic [SAMPLE_WIDTH-1:0] a, input logic [SAMPLE_WIDTH-1:0] b);
    pending_samples.insert(pending_samples.size(), a);
    pending_samples.insert(pending_samples.size(), b);
  endtask

  initial begin
    while (rst) @(posedge clk);
    send_gap_pct = 7;
    recv_stall_pct = 53;

    // All-negative pattern: window is zero out of reset, so only the
    // sixteenth sample may match; burst length still at its reset value
    write_reg(REG_PREAMBLE_PATTERN, '0);
    for (int i = 0; i < WINDOW_LEN; i++)
      pending_samples.insert(pending_samples.size(), signed_sample(1'b0));
    push_pair(16'h7FFF, 16'h0001);
    settle();
    // Zero length acts as one, and is below the count already reached
    write_reg(REG_PAYLOAD_SYMBOLS, '0);
    push_pair(16'h0000, 16'hFFFF);
    // Window kept across bursts: one negative sample re-arms at once
    pending_samples.insert(pending_samples.size(), 16'h8000);
    push_pair(16'h0001, 16'h0000);
    settle();
    // Upper data bits beyond the register width are dropped
    write_reg(REG_PAYLOAD_SYMBOLS, 16'hE004);
    pending_samples.insert(pending_samples.size(), 16'hFFFF);
    push_pair(16'h8000, 16'h7FFF);
    push_pair(16'h0001, 16'h7FFF);
    push_pair(16'h7FFF, 16'h8000);
    settle();
    // Lowered length mid-burst ends it on the next symbol
    write_reg(REG_PAYLOAD_SYMBOLS, 16'd2);
    push_pair(16'hFFFF, 16'h0000);
    settle();

    // Sender rarely idles, receiver often stalls, one long hold-off
    write_reg(REG_PREAMBLE_PATTERN, CFG_DATA_W'($urandom));
    write_reg(REG_PAYLOAD_SYMBOLS, CFG_DATA_W'($urandom_range(1, 8)));
    hold_requests++;
    push_traffic(220);
    settle();

    // Roles swapped; all-ones pattern
    send_gap_pct = 53;
    recv_stall_pct = 7;
    write_reg(REG_PREAMBLE_PATTERN, '1);
    write_reg(REG_PAYLOAD_SYMBOLS, CFG_DATA_W'($urandom_range(1, 8)));
    push_traffic(220);
    settle();

    // No random idling on either side, one long hold-off
    send_gap_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_PREAMBLE_PATTERN, CFG_DATA_W'($urandom));
    write_reg(REG_PAYLOAD_SYMBOLS, 16'd1);
    hold_requests++;
    push_traffic(220);
    settle();

    // Long burst length: run part of a burst, then cut it short
    write_reg(REG_PAYLOAD_SYMBOLS, 16'd4096);
    push_preamble(pattern_reg);
    push_noise(160);
    settle();
    write_reg(REG_PAYLOAD_SYMBOLS, 16'd1);
    push_pair(16'h7FFF, 16'h0000);
    settle();

    if (mismatch_count == 0 && expected_symbols.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== preamble_gated_symbol_slicer.f =====
src/pss_pkg.sv
src/pss_core.sv
src/preamble_gated_symbol_slicer.sv
tb/testbench.sv
